@@ src/cfbp_pkg.sv @@
// Shared types, constants and helper functions for the contact friction box projection.
// Used by the divider cell, the divider chain and the top level.
`default_nettype none
package cfbp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_DW = 33;
  localparam logic [15:0] NREG_RESET = 16'd66;
  localparam logic REG_NORMAL_IDX = 1'b0;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -67'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < -hi) begin
      r = -hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/cfbp_div_cell.sv @@
// One restoring division cell: produces one quotient bit per transfer and hands on.
// Depends on cfbp_pkg for the control struct.
`default_nettype none
module cfbp_div_cell import cfbp_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_ctl_t      ctl_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [NW-1:0] dvd_i,
  input  wire logic [NW-1:0] q_i,
  input  wire logic [SW-1:0] side_i,
  output div_ctl_t           ctl_o,
  output logic [DW-1:0]      rem_o,
  output logic [DW-1:0]      den_o,
  output logic [NW-1:0]      dvd_o,
  output logic [NW-1:0]      q_o,
  output logic [SW-1:0]      side_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;
  div_ctl_t      ctl_r;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] dvd_r, q_r;
  logic [SW-1:0] side_r;

  assign trial = {rem_i, dvd_i[NW-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.neg  <= ctl_i.neg;
    ctl_r.zero <= ctl_i.zero;
    rem_r      <= ge ? diff[DW-1:0] : trial[DW-1:0];
    den_r      <= den_i;
    dvd_r      <= {dvd_i[NW-2:0], 1'b0};
    q_r        <= {q_i[NW-2:0], ge};
    side_r     <= side_i;
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign dvd_o  = dvd_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

@@ src/cfbp_div_chain.sv @@
// Pipelined signed fixed-point divider built from a row of division cells.
// Depends on cfbp_pkg and cfbp_div_cell; returns the saturated 32-bit quotient.
`default_nettype none
module cfbp_div_chain import cfbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [32:0] den_i,
  input  wire logic [SW-1:0]      side_i,
  output logic                    valid_o,
  output logic signed [31:0]      q_o,
  output logic [SW-1:0]           side_o
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int DW = DIV_DW;

  div_ctl_t      ctl [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic [DW-1:0] den [0:NW];
  logic [NW-1:0] dvd [0:NW];
  logic [NW-1:0] quo [0:NW];
  logic [SW-1:0] sd  [0:NW];

  div_ctl_t      ctl0_r;
  logic [31:0]   nmag_r;
  logic [DW-1:0] dmag_r;
  logic [SW-1:0] side0_r;
  logic          valid_out_r;
  logic signed [31:0] q_r;
  logic [SW-1:0] side_out_r;
  logic [NW-1:0] mag;
  logic          ovf;
  logic signed [31:0] q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
      valid_out_r  <= 1'b0;
    end else begin
      ctl0_r.valid <= valid_i;
      valid_out_r  <= ctl[NW].valid;
    end
    ctl0_r.neg  <= num_i[31] ^ den_i[32];
    ctl0_r.zero <= num_i == 32'sd0;
    nmag_r      <= num_i[31] ? 32'(-33'(num_i)) : 32'(num_i);
    dmag_r      <= den_i[32] ? DW'(-34'(den_i)) : DW'(den_i);
    side0_r     <= side_i;
    q_r         <= q_nxt;
    side_out_r  <= sd[NW];
  end

  assign ctl[0] = ctl0_r;
  assign rem[0] = '0;
  assign den[0] = dmag_r;
  assign dvd[0] = {nmag_r, {FRAC_BITS{1'b0}}};
  assign quo[0] = '0;
  assign sd[0]  = side0_r;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    cfbp_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl[k]),
      .rem_i  (rem[k]),
      .den_i  (den[k]),
      .dvd_i  (dvd[k]),
      .q_i    (quo[k]),
      .side_i (sd[k]),
      .ctl_o  (ctl[k+1]),
      .rem_o  (rem[k+1]),
      .den_o  (den[k+1]),
      .dvd_o  (dvd[k+1]),
      .q_o    (quo[k+1]),
      .side_o (sd[k+1])
    );
  end

  assign mag = quo[NW];
  assign ovf = |mag[NW-1:31];

  always_comb begin
    if (ctl[NW].zero) begin
      q_nxt = 32'sd0;
    end else if (ctl[NW].neg) begin
      q_nxt = ovf ? 32'sh8000_0000 : -$signed(mag[31:0]);
    end else begin
      q_nxt = ovf ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end
  end

  assign valid_o = valid_out_r;
  assign q_o     = q_r;
  assign side_o  = side_out_r;

endmodule
`default_nettype wire

@@ src/contact_friction_box_projection.sv @@
// Projected Gauss-Seidel update of one contact with a Coulomb friction box, Q16.16.
// The data passes through three divider rows in turn: the normal, then the u and then the v impulse.
// Throughput is one contact per cycle; busy stays low and the receiver cannot stall.
// Synchronous reset clears all valid flags and sets the regularization register to 66.
// Depends on cfbp_pkg and cfbp_div_chain.
`default_nettype none
module contact_friction_box_projection import cfbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_a_nn,
  input  wire logic signed [31:0] in_a_nu,
  input  wire logic signed [31:0] in_a_nv,
  input  wire logic signed [31:0] in_a_uu,
  input  wire logic signed [31:0] in_a_uv,
  input  wire logic signed [31:0] in_a_vv,
  input  wire logic signed [31:0] in_rhs_normal,
  input  wire logic signed [31:0] in_rhs_tangent_u,
  input  wire logic signed [31:0] in_rhs_tangent_v,
  input  wire logic signed [31:0] in_prev_friction_u,
  input  wire logic signed [31:0] in_prev_friction_v,
  input  wire logic [18:0]        in_friction_coef,
  output logic                    out_valid,
  output logic [30:0]             out_normal_impulse,
  output logic signed [31:0]      out_friction_u,
  output logic signed [31:0]      out_friction_v,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int NW  = 32 + FRAC_BITS;
  localparam int LAT = 3 * NW + 16;
  localparam int RW  = 65 - FRAC_BITS;
  localparam int UW  = 51 - FRAC_BITS;
  localparam logic signed [64:0] HALF_S = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic [50:0] HALF_U = 51'd1 << (FRAC_BITS - 1);
  localparam int SWN = 8 * 32 + 19;
  localparam int SWU = 31 + 32 + 4 * 32;
  localparam int SWV = 31 + 32 + 32;

  logic [15:0] nreg_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_NORMAL_IDX) ? {16'd0, nreg_r} : 32'd0;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nreg_r <= NREG_RESET;
    end else if (cfg_wr && paddr[2:2] == REG_NORMAL_IDX) begin
      nreg_r <= pwdata[15:0];
    end
  end

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r, vi_r, vj_r;

  logic signed [31:0] a_nn_a_r, a_nu_a_r, a_nv_a_r, a_uu_a_r, a_uv_a_r, a_vv_a_r;
  logic signed [31:0] rn_a_r, ru_a_r, rv_a_r, pu_a_r, pv_a_r;
  logic [18:0]        mu_a_r;

  logic signed [63:0] p1_b_r, p2_b_r;
  logic signed [32:0] den_b_r;
  logic signed [31:0] rn_b_r;
  logic [SWN-1:0]     sn_b_r;

  logic signed [64:0] s1_b, s2_b;
  logic signed [RW-1:0] r1_c_r, r2_c_r;
  logic signed [32:0] den_c_r;
  logic signed [31:0] rn_c_r;
  logic [SWN-1:0]     sn_c_r;

  logic signed [66:0] sum_n;
  logic               vn_o;
  logic signed [31:0] qn_o;
  logic [SWN-1:0]     sn_o;

  logic [30:0]        n_d_r;
  logic [SWN-1:0]     sn_d_r;
  logic signed [31:0] a_nu_d, a_nv_d, a_uu_d, a_uv_d, a_vv_d, ru_d, rv_d, pv_d;
  logic [18:0]        mu_d;

  logic [49:0]        pm_e_r;
  logic signed [63:0] p1_e_r, p2_e_r;
  logic [30:0]        n_e_r;
  logic signed [31:0] a_nv_e_r, a_uu_e_r, a_uv_e_r, a_vv_e_r, ru_e_r, rv_e_r;

  logic [50:0]        sm_e;
  logic [UW-1:0]      sq_e;
  logic signed [64:0] s1_e, s2_e;
  logic [31:0]        hi_f_r;
  logic signed [RW-1:0] r1_f_r, r2_f_r;
  logic [30:0]        n_f_r;
  logic signed [31:0] a_nv_f_r, a_uu_f_r, a_uv_f_r, a_vv_f_r, ru_f_r, rv_f_r;

  logic signed [66:0] sum_u;
  logic               vu_o;
  logic signed [31:0] qu_o;
  logic [SWU-1:0]     su_o;
  logic [30:0]        n_u;
  logic signed [31:0] hi_u, a_nv_u, a_uv_u, a_vv_u, rv_u;

  logic [30:0]        n_g_r;
  logic signed [31:0] hi_g_r, fu_g_r, a_nv_g_r, a_uv_g_r, a_vv_g_r, rv_g_r;

  logic signed [63:0] p1_h_r, p2_h_r;
  logic [30:0]        n_h_r;
  logic signed [31:0] hi_h_r, fu_h_r, a_vv_h_r, rv_h_r;

  logic signed [64:0] s1_h, s2_h;
  logic signed [RW-1:0] r1_i_r, r2_i_r;
  logic [30:0]        n_i_r;
  logic signed [31:0] hi_i_r, fu_i_r, a_vv_i_r, rv_i_r;

  logic signed [66:0] sum_v;
  logic               vv_o;
  logic signed [31:0] qv_o;
  logic [SWV-1:0]     sv_o;
  logic [30:0]        n_v;
  logic signed [31:0] hi_v, fu_v;

  logic [30:0]        n_j_r;
  logic signed [31:0] fu_j_r, fv_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vi_r <= 1'b0;
      vj_r <= 1'b0;
    end else begin
      va_r <= start && !busy;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vn_o;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vu_o;
      vh_r <= vg_r;
      vi_r <= vh_r;
      vj_r <= vv_o;
    end
  end

  assign s1_b  = 65'(p1_b_r) + HALF_S;
  assign s2_b  = 65'(p2_b_r) + HALF_S;
  assign sum_n = 67'(rn_c_r) - 67'(r1_c_r) - 67'(r2_c_r);

  always_ff @(posedge clk) begin
    a_nn_a_r <= in_a_nn;
    a_nu_a_r <= in_a_nu;
    a_nv_a_r <= in_a_nv;
    a_uu_a_r <= in_a_uu;
    a_uv_a_r <= in_a_uv;
    a_vv_a_r <= in_a_vv;
    rn_a_r   <= in_rhs_normal;
    ru_a_r   <= in_rhs_tangent_u;
    rv_a_r   <= in_rhs_tangent_v;
    pu_a_r   <= in_prev_friction_u;
    pv_a_r   <= in_prev_friction_v;
    mu_a_r   <= in_friction_coef;

    p1_b_r  <= a_nu_a_r * pu_a_r;
    p2_b_r  <= a_nv_a_r * pv_a_r;
    den_b_r <= 33'(a_nn_a_r) + $signed({17'd0, nreg_r});
    rn_b_r  <= rn_a_r;
    sn_b_r  <= {a_nu_a_r, a_nv_a_r, a_uu_a_r, a_uv_a_r, a_vv_a_r,
                ru_a_r, rv_a_r, pv_a_r, mu_a_r};

    r1_c_r  <= s1_b[64:FRAC_BITS];
    r2_c_r  <= s2_b[64:FRAC_BITS];
    den_c_r <= den_b_r;
    rn_c_r  <= rn_b_r;
    sn_c_r  <= sn_b_r;
  end

  cfbp_div_chain #(.FRAC_BITS(FRAC_BITS), .SW(SWN)) u_div_n (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vc_r),
    .num_i   (sat32(sum_n)),
    .den_i   (den_c_r),
    .side_i  (sn_c_r),
    .valid_o (vn_o),
    .q_o     (qn_o),
    .side_o  (sn_o)
  );

  assign {a_nu_d, a_nv_d, a_uu_d, a_uv_d, a_vv_d, ru_d, rv_d, pv_d, mu_d} = sn_d_r;

  assign sm_e = {1'b0, pm_e_r} + HALF_U;
  assign sq_e = sm_e[50:FRAC_BITS];
  assign s1_e = 65'(p1_e_r) + HALF_S;
  assign s2_e = 65'(p2_e_r) + HALF_S;

  always_ff @(posedge clk) begin
    n_d_r  <= qn_o[31] ? 31'd0 : qn_o[30:0];
    sn_d_r <= sn_o;

    pm_e_r   <= mu_d * n_d_r;
    p1_e_r   <= a_nu_d * $signed({1'b0, n_d_r});
    p2_e_r   <= a_uv_d * pv_d;
    n_e_r    <= n_d_r;
    a_nv_e_r <= a_nv_d;
    a_uu_e_r <= a_uu_d;
    a_uv_e_r <= a_uv_d;
    a_vv_e_r <= a_vv_d;
    ru_e_r   <= ru_d;
    rv_e_r   <= rv_d;

    hi_f_r   <= (51'(sq_e) > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(sq_e);
    r1_f_r   <= s1_e[64:FRAC_BITS];
    r2_f_r   <= s2_e[64:FRAC_BITS];
    n_f_r    <= n_e_r;
    a_nv_f_r <= a_nv_e_r;
    a_uu_f_r <= a_uu_e_r;
    a_uv_f_r <= a_uv_e_r;
    a_vv_f_r <= a_vv_e_r;
    ru_f_r   <= ru_e_r;
    rv_f_r   <= rv_e_r;
  end

  assign sum_u = 67'(ru_f_r) - 67'(r1_f_r) - 67'(r2_f_r);

  cfbp_div_chain #(.FRAC_BITS(FRAC_BITS), .SW(SWU)) u_div_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vf_r),
    .num_i   (sat32(sum_u)),
    .den_i   (33'(a_uu_f_r)),
    .side_i  ({n_f_r, hi_f_r, a_nv_f_r, a_uv_f_r, a_vv_f_r, rv_f_r}),
    .valid_o (vu_o),
    .q_o     (qu_o),
    .side_o  (su_o)
  );

  assign {n_u, hi_u, a_nv_u, a_uv_u, a_vv_u, rv_u} = su_o;

  assign s1_h = 65'(p1_h_r) + HALF_S;
  assign s2_h = 65'(p2_h_r) + HALF_S;

  always_ff @(posedge clk) begin
    n_g_r    <= n_u;
    hi_g_r   <= hi_u;
    fu_g_r   <= clamp32(qu_o, hi_u);
    a_nv_g_r <= a_nv_u;
    a_uv_g_r <= a_uv_u;
    a_vv_g_r <= a_vv_u;
    rv_g_r   <= rv_u;

    p1_h_r   <= a_nv_g_r * $signed({1'b0, n_g_r});
    p2_h_r   <= a_uv_g_r * fu_g_r;
    n_h_r    <= n_g_r;
    hi_h_r   <= hi_g_r;
    fu_h_r   <= fu_g_r;
    a_vv_h_r <= a_vv_g_r;
    rv_h_r   <= rv_g_r;

    r1_i_r   <= s1_h[64:FRAC_BITS];
    r2_i_r   <= s2_h[64:FRAC_BITS];
    n_i_r    <= n_h_r;
    hi_i_r   <= hi_h_r;
    fu_i_r   <= fu_h_r;
    a_vv_i_r <= a_vv_h_r;
    rv_i_r   <= rv_h_r;
  end

  assign sum_v = 67'(rv_i_r) - 67'(r1_i_r) - 67'(r2_i_r);

  cfbp_div_chain #(.FRAC_BITS(FRAC_BITS), .SW(SWV)) u_div_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vi_r),
    .num_i   (sat32(sum_v)),
    .den_i   (33'(a_vv_i_r)),
    .side_i  ({n_i_r, hi_i_r, fu_i_r}),
    .valid_o (vv_o),
    .q_o     (qv_o),
    .side_o  (sv_o)
  );

  assign {n_v, hi_v, fu_v} = sv_o;

  always_ff @(posedge clk) begin
    n_j_r  <= n_v;
    fu_j_r <= fu_v;
    fv_j_r <= clamp32(qv_o, hi_v);
  end

  assign out_valid          = vj_r;
  assign out_normal_impulse = n_j_r;
  assign out_friction_u     = fu_j_r;
  assign out_friction_v     = fv_j_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching input transfer");

  a_no_output_loss: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> ##(LAT - 3) out_valid)
    else $error("item lost in the pipeline");

  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_normal_impulse == 31'd0) |->
      (out_friction_u == 32'sd0 && out_friction_v == 32'sd0))
    else $error("friction nonzero with zero normal impulse");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2:2] == REG_NORMAL_IDX) |=> nreg_r == $past(pwdata[15:0]))
    else $error("regularization write not taken");

endmodule
`default_nettype wire

@@ tb/sv/contact_friction_box_projection_tb.sv @@
// Testbench for contact_friction_box_projection: directed and random contacts checked
// against a fixed-point predictor of the projected Gauss-Seidel friction box update.
// Depends on cfbp_pkg and the contact_friction_box_projection RTL.
`default_nettype none
module contact_friction_box_projection_tb import cfbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int LATENCY = 3 * (32 + FB) + 16;
  localparam longint MAX_CYCLES = 400000;
  localparam logic [2:0] ADDR_NREG = 3'(4 * REG_NORMAL_IDX);
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] a_nn, a_nu, a_nv, a_uu, a_uv, a_vv;
    logic signed [31:0] rn, ru, rv, pu, pv;
    logic [18:0] mu;
  } contact_t;

  typedef struct packed {
    logic [30:0] normal;
    logic signed [31:0] fu, fv;
  } impulse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  contact_t cur = '0;
  logic out_valid;
  logic [30:0] out_normal_impulse;
  logic signed [31:0] out_friction_u, out_friction_v;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  contact_t pending_contacts[$];
  impulse_t expected_impulses[$];
  logic [15:0] nreg_model;
  int errors = 0;
  int checked = 0;
  int cfg_writes = 0;
  longint cycles = 0;

  always #10 clk = ~clk;

  contact_friction_box_projection #(.FRAC_BITS(FB)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_a_nn(cur.a_nn), .in_a_nu(cur.a_nu), .in_a_nv(cur.a_nv),
    .in_a_uu(cur.a_uu), .in_a_uv(cur.a_uv), .in_a_vv(cur.a_vv),
    .in_rhs_normal(cur.rn), .in_rhs_tangent_u(cur.ru), .in_rhs_tangent_v(cur.rv),
    .in_prev_friction_u(cur.pu), .in_prev_friction_v(cur.pv),
    .in_friction_coef(cur.mu),
    .out_valid, .out_normal_impulse, .out_friction_u, .out_friction_v,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  function automatic longint rnd_prod(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint sat_s32(longint v);
    return v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
  endfunction

  function automatic longint row_solve(longint rhs, longint c1, longint x1,
                                       longint c2, longint x2, longint den);
    longint num;
    num = sat_s32(rhs - rnd_prod(c1, x1) - rnd_prod(c2, x2));
    if (den == 0) return num > 0 ? S_MAX : (num < 0 ? S_MIN : 64'sd0);
    return sat_s32((num * (64'sd1 <<< FB)) / den);
  endfunction

  function automatic longint box(longint v, longint hi);
    return v > hi ? hi : (v < -hi ? -hi : v);
  endfunction

  function automatic impulse_t project_contact(contact_t c, logic [15:0] nreg);
    longint n, hi, fu, fv;
    impulse_t r;
    n = row_solve(c.rn, c.a_nu, c.pu, c.a_nv, c.pv, longint'(c.a_nn) + longint'(nreg));
    if (n < 0) n = 0;
    hi = rnd_prod(longint'(c.mu), n);
    if (hi > S_MAX) hi = S_MAX;
    fu = box(row_solve(c.ru, c.a_nu, n, c.a_uv, c.pv, c.a_uu), hi);
    fv = box(row_solve(c.rv, c.a_nv, n, c.a_uv, fu, c.a_vv), hi);
    r.normal = n[30:0];
    r.fu = fu[31:0];
    r.fv = fv[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Driver: gaps between transfers are mostly short with an occasional long one.
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_impulses.push_back(project_contact(cur, nreg_model));
    end
    if (start && !(rst_n && !busy)) begin
      // Hold the current transfer.
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (rst_n && pending_contacts.size() > 0) begin
      cur <= pending_contacts.pop_front();
      start <= 1'b1;
      gap <= ($urandom_range(0, 3) == 0) ?
             (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
             : 0;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && rst_n) begin
      if (expected_impulses.size() == 0) begin
        report_mismatch("unexpected result", out_normal_impulse, -1);
      end else begin
        impulse_t e;
        e = expected_impulses.pop_front();
        checked++;
        if (out_normal_impulse !== e.normal)
          report_mismatch("normal_impulse", out_normal_impulse, e.normal);
        if (out_friction_u !== e.fu) report_mismatch("friction_u", out_friction_u, e.fu);
        if (out_friction_v !== e.fv) report_mismatch("friction_v", out_friction_v, e.fv);
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("contact_friction_box_projection_tb NOT OK");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_NREG) nreg_model = data[15:0];
    cfg_writes++;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic contact_t rnd_contact();
    contact_t c;
    c.a_nn = ($urandom_range(0, 7) == 0) ? rnd_word() : 32'($urandom_range(0, 32'h0008_0000));
    c.a_uu = ($urandom_range(0, 7) == 0) ? rnd_word() : 32'($urandom_range(0, 32'h0008_0000));
    c.a_vv = ($urandom_range(0, 7) == 0) ? rnd_word() : 32'($urandom_range(0, 32'h0008_0000));
    c.a_nu = rnd_word(); c.a_nv = rnd_word(); c.a_uv = rnd_word();
    c.rn = rnd_word(); c.ru = rnd_word(); c.rv = rnd_word();
    c.pu = rnd_word(); c.pv = rnd_word();
    case ($urandom_range(0, 5))
      0: c.mu = 19'($urandom);
      1: c.mu = 19'h7FFFF;
      2: c.mu = 19'd0;
      default: c.mu = 19'($urandom_range(0, 262144));
    endcase
    return c;
  endfunction

  task automatic drain();
    wait (pending_contacts.size() == 0);
    @(posedge clk);
    while (start || expected_impulses.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  initial begin
    contact_t c;
    logic [15:0] nreg_settings[4];
    nreg_settings = '{16'd0, 16'hFFFF, 16'd1, 16'd66};
    nreg_model = NREG_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    c = '0; pending_contacts.push_back(c);
    c.a_nn = 32'sh0001_0000; c.rn = 32'sh0002_0000; c.mu = 19'h08000;
    c.a_uu = 32'sh0001_0000; c.a_vv = 32'sh0001_0000;
    c.ru = 32'sh0000_4000; c.rv = -32'sh0004_0000;
    pending_contacts.push_back(c);
    c.rn = -32'sh0002_0000; pending_contacts.push_back(c);
    c.rn = 32'sh0002_0000; c.a_uu = 0; c.a_vv = 0; pending_contacts.push_back(c);
    c.ru = -32'sh0000_4000; c.rv = 0; pending_contacts.push_back(c);
    c.mu = 19'h7FFFF; c.rn = 32'sh7FFF_FFFF; pending_contacts.push_back(c);
    c = '1; c.mu = 19'h40000; pending_contacts.push_back(c);
    c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 19'h40000};
    pending_contacts.push_back(c);
    c.a_nn = -32'sd66; c.rn = 32'sh0000_1000; pending_contacts.push_back(c);
    c.rn = 0; pending_contacts.push_back(c);
    c.rn = -32'sh0000_1000; pending_contacts.push_back(c);
    for (int i = 0; i < 8; i++) pending_contacts.push_back(rnd_contact());
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) cfg_write(ADDR_NREG, {16'($urandom_range(0, 65535)), nreg_settings[phase]});
      else cfg_write(ADDR_UNUSED, $urandom);
      for (int i = 0; i < 100; i++) pending_contacts.push_back(rnd_contact());
      drain();
    end

    $display("checked %0d contact updates over %0d register writes", checked, cfg_writes);
    if (errors == 0 && expected_impulses.size() == 0) begin
      $display("contact_friction_box_projection_tb OK");
    end else begin
      $display("contact_friction_box_projection_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/cfbp_pkg.sv
src/cfbp_div_cell.sv
src/cfbp_div_chain.sv
src/contact_friction_box_projection.sv
tb/sv/contact_friction_box_projection_tb.sv
